/* sv/bmhq_pkg.sv */
`timescale 1ns / 1ps
package bmhq_pkg;

  localparam int HEAP_DEPTH = 1024;
  localparam int AW = $clog2(HEAP_DEPTH);
  localparam int CW = $clog2(HEAP_DEPTH + 1);
  localparam int KEY_W = 31;
  localparam int TAG_W = 16;
  localparam int ENT_W = KEY_W + TAG_W;

  localparam logic REQ_INSERT = 1'b0;
  localparam logic REQ_EXTRACT = 1'b1;

  localparam logic [1:0] ST_DONE = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;

  typedef struct packed {
    logic req_type;
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } req_t;

  typedef struct packed {
    logic [KEY_W-1:0] out_key;
    logic [TAG_W-1:0] out_tag;
    logic [1:0] status;
    logic now_empty;
    logic [10:0] entry_count;
  } rsp_t;

  typedef struct packed {
    logic [KEY_W-1:0] key;
    logic [TAG_W-1:0] tag;
  } ent_t;

  // Datapath commands issued by the controller.
  typedef enum logic [3:0] {
    C_NOP,
    C_LOAD,     // capture request, set pos
    C_INS,      // write new entry at pos=count, count++
    C_RD_PAR,   // read parent of pos
    C_UP_CMP,   // compare with parent, swap if less
    C_EX_ROOT,  // read root
    C_EX_LAST,  // read last, save root as result
    C_EX_PUT,   // write last at root, count--, pos=0
    C_RD_L,     // read left child
    C_RD_R,     // read right child, latch left
    C_DN_CMP,   // choose and swap
    C_WB2,      // second write of a swap
    C_RESULT    // load output register
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic is_extract;
    logic at_root;
    logic has_left;
    logic has_right;
    logic swap;
  } stat_t;

endpackage

/* sv/binary_min_heap_queue.sv */
`timescale 1ns / 1ps
// Min-heap priority queue of up to HEAP_DEPTH (key, tag) entries in one
// single-port memory. Each request beat yields one result beat. An insert
// writes the new entry at the end, then per level reads the parent and swaps
// while the new key is less; an extract reads the root and the last entry,
// writes the last at the root, then per level reads the children and swaps
// with the smaller while it is less; a refused request goes straight to its
// result. The single memory port, with its registered read, sets the cost of
// each level. A new request is taken only while the controller is idle, once
// the previous result beat has been accepted or in the cycle it is accepted.
module binary_min_heap_queue
  import bmhq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  req_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output rsp_t out_data
);

  cmd_t cmd;
  stat_t stat;

  bmhq_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
  );

  bmhq_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .req(in_data), .stat(stat), .rsp(out_data)
  );

endmodule

/* sv/bmhq_datapath.sv */
`timescale 1ns / 1ps
module bmhq_datapath
  import bmhq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  cmd_t cmd,
  input  req_t req,
  output stat_t stat,
  output rsp_t rsp
);

  // Heap storage: one port, registered read.
  ent_t mem [HEAP_DEPTH];
  ent_t rdata;
  logic we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  ent_t wdata;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  logic [CW-1:0] count;
  logic [AW-1:0] pos;
  logic req_ext;
  ent_t cur;
  ent_t lch;
  ent_t res;
  logic [1:0] st;
  logic swap_r;
  ent_t wb2_data;
  logic [AW-1:0] wb2_addr;

  logic [CW:0] lidx;
  logic [CW:0] ridx;
  assign lidx = {{(CW-AW){1'b0}}, pos, 1'b1};
  assign ridx = lidx + {{CW{1'b0}}, 1'b1};

  logic [AW-1:0] par;
  assign par = (pos - {{(AW-1){1'b0}}, 1'b1}) >> 1;

  // Sift-down choice: left child latched, right child in rdata.
  logic pick_l;
  logic pick_r;
  always_comb begin
    pick_l = stat.has_left && (lch.key < cur.key);
    pick_r = stat.has_right && (rdata.key < (pick_l ? lch.key : cur.key));
  end

  assign stat.full = (count == CW'(HEAP_DEPTH));
  assign stat.empty = (count == '0);
  assign stat.is_extract = req_ext;
  assign stat.at_root = (pos == '0);
  assign stat.has_left = (lidx < {1'b0, count});
  assign stat.has_right = (ridx < {1'b0, count});
  assign stat.swap = swap_r;

  // Memory port control.
  always_comb begin
    we = 1'b0;
    waddr = pos;
    wdata = cur;
    raddr = pos;
    unique case (cmd)
      C_INS: begin
        we = 1'b1;
        waddr = count[AW-1:0];
        wdata = cur;
      end
      C_RD_PAR: raddr = par;
      C_EX_ROOT: raddr = '0;
      C_EX_LAST: raddr = AW'(count - CW'(1));
      C_EX_PUT: begin
        we = 1'b1;
        waddr = '0;
        wdata = rdata;
      end
      C_RD_L: raddr = lidx[AW-1:0];
      C_RD_R: raddr = ridx[AW-1:0];
      C_UP_CMP: begin
        we = (cur.key < rdata.key);
        waddr = par;
        wdata = cur;
      end
      C_DN_CMP: begin
        we = pick_l || pick_r;
        waddr = pos;
        wdata = pick_r ? rdata : lch;
      end
      C_WB2: begin
        we = 1'b1;
        waddr = wb2_addr;
        wdata = wb2_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      swap_r <= 1'b0;
    end else begin
      unique case (cmd)
        C_LOAD: begin
          req_ext <= req.req_type;
          cur <= '{key: req.key, tag: req.tag};
          res <= '0;
          pos <= count[AW-1:0];
          // Status codes for refused requests.
          if (req.req_type == REQ_EXTRACT && count == '0) begin
            st <= ST_EMPTY;
          end else if (req.req_type == REQ_INSERT && count == CW'(HEAP_DEPTH)) begin
            st <= ST_FULL;
          end else begin
            st <= ST_DONE;
          end
        end
        C_INS: count <= count + CW'(1);
        C_UP_CMP: begin
          swap_r <= cur.key < rdata.key;
          wb2_addr <= pos;
          wb2_data <= rdata;
          if (cur.key < rdata.key) begin
            pos <= par;
          end
        end
        C_EX_LAST: res <= rdata;
        C_EX_PUT: begin
          cur <= rdata;
          count <= count - CW'(1);
          pos <= '0;
        end
        C_RD_R: lch <= rdata;
        C_DN_CMP: begin
          swap_r <= pick_l || pick_r;
          wb2_data <= cur;
          if (pick_r) begin
            wb2_addr <= ridx[AW-1:0];
            pos <= ridx[AW-1:0];
          end else begin
            wb2_addr <= lidx[AW-1:0];
            if (pick_l) begin
              pos <= lidx[AW-1:0];
            end
          end
        end
        C_RESULT: begin
          rsp.out_key <= res.key;
          rsp.out_tag <= res.tag;
          rsp.status <= st;
          rsp.now_empty <= (count == '0);
          rsp.entry_count <= 11'(count);
        end
        default: ;
      endcase
    end
  end

endmodule

/* sv/bmhq_ctrl.sv */
`timescale 1ns / 1ps
module bmhq_ctrl
  import bmhq_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  output logic out_valid,
  input  logic out_stall,
  input  stat_t stat,
  output cmd_t cmd
);

  typedef enum logic [3:0] {
    S_IDLE, S_DEC, S_INS, S_UP_RD, S_UP_CMP, S_UP_WB,
    S_EX_ROOT, S_EX_LAST, S_EX_PUT, S_DN_L, S_DN_R, S_DN_CMP, S_DN_WB,
    S_RES
  } state_t;

  state_t state;
  state_t state_next;

  logic take;
  assign in_stall = (state != S_IDLE) || (out_valid && out_stall);
  assign take = in_valid && !in_stall;

  // Command decode and next state.
  always_comb begin
    cmd = C_NOP;
    state_next = state;
    unique case (state)
      S_IDLE: if (take) begin
        cmd = C_LOAD;
        state_next = S_DEC;
      end
      S_DEC: begin
        if (stat.is_extract) begin
          state_next = stat.empty ? S_RES : S_EX_ROOT;
        end else begin
          state_next = stat.full ? S_RES : S_INS;
        end
      end
      S_INS: begin
        cmd = C_INS;
        state_next = S_UP_RD;
      end
      S_UP_RD: begin
        if (stat.at_root) begin
          state_next = S_RES;
        end else begin
          cmd = C_RD_PAR;
          state_next = S_UP_CMP;
        end
      end
      S_UP_CMP: begin
        cmd = C_UP_CMP;
        state_next = S_UP_WB;
      end
      S_UP_WB: begin
        if (stat.swap) begin
          cmd = C_WB2;
          state_next = S_UP_RD;
        end else begin
          state_next = S_RES;
        end
      end
      S_EX_ROOT: begin
        cmd = C_EX_ROOT;
        state_next = S_EX_LAST;
      end
      S_EX_LAST: begin
        cmd = C_EX_LAST;
        state_next = S_EX_PUT;
      end
      S_EX_PUT: begin
        cmd = C_EX_PUT;
        state_next = S_DN_L;
      end
      S_DN_L: begin
        if (stat.has_left) begin
          cmd = C_RD_L;
          state_next = S_DN_R;
        end else begin
          state_next = S_RES;
        end
      end
      S_DN_R: begin
        cmd = C_RD_R;
        state_next = S_DN_CMP;
      end
      S_DN_CMP: begin
        cmd = C_DN_CMP;
        state_next = S_DN_WB;
      end
      S_DN_WB: begin
        if (stat.swap) begin
          cmd = C_WB2;
          state_next = S_DN_L;
        end else begin
          state_next = S_RES;
        end
      end
      S_RES: begin
        cmd = C_RESULT;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State and output beat flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd == C_RESULT) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

/* sim/tb_binary_min_heap_queue.sv */
`timescale 1ns / 1ps
module tb_binary_min_heap_queue;
  import bmhq_pkg::*;

  logic clk;
  logic rst;
  logic in_valid;
  logic in_stall;
  req_t in_data;
  logic out_valid;
  logic out_stall;
  rsp_t out_data;

  binary_min_heap_queue uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  // Shadow heap that mirrors the queue contents.
  logic [KEY_W-1:0] shadow_key [HEAP_DEPTH];
  logic [TAG_W-1:0] shadow_tag [HEAP_DEPTH];
  int shadow_fill;
  rsp_t pending_rsp [$];
  int err_count;
  bit send_done;
  bit long_hold;
  int idle_cycles;
  bit fix_armed;
  rsp_t fix_rsp;

  // Directed rows; a result with check_fixed set is compared to its typed value too.
  typedef struct {
    req_t req;
    bit check_fixed;
    rsp_t fixed;
  } dir_row_t;

  function automatic rsp_t mk_rsp(logic [KEY_W-1:0] k, logic [TAG_W-1:0] t,
                                  logic [1:0] st, int cnt);
    rsp_t r;
    r.out_key = k;
    r.out_tag = t;
    r.status = st;
    r.now_empty = (cnt == 0);
    r.entry_count = cnt[10:0];
    return r;
  endfunction

  function automatic void swap_slot(int a, int b);
    logic [KEY_W-1:0] k;
    logic [TAG_W-1:0] t;
    k = shadow_key[a];
    t = shadow_tag[a];
    shadow_key[a] = shadow_key[b];
    shadow_tag[a] = shadow_tag[b];
    shadow_key[b] = k;
    shadow_tag[b] = t;
  endfunction

  // Apply one request to the shadow heap and return the response it should give.
  function automatic rsp_t heap_apply(req_t rq);
    int pos;
    int up;
    int best;
    logic [KEY_W-1:0] rk;
    logic [TAG_W-1:0] rt;
    logic [1:0] st;
    rk = '0;
    rt = '0;
    st = ST_DONE;
    if (rq.req_type == REQ_INSERT) begin
      if (shadow_fill >= HEAP_DEPTH) begin
        st = ST_FULL;
      end else begin
        pos = shadow_fill;
        shadow_key[pos] = rq.key;
        shadow_tag[pos] = rq.tag;
        shadow_fill++;
        while (pos > 0) begin
          up = (pos - 1) / 2;
          if (shadow_key[pos] < shadow_key[up]) begin
            swap_slot(pos, up);
            pos = up;
          end else break;
        end
      end
    end else begin
      if (shadow_fill == 0) begin
        st = ST_EMPTY;
      end else begin
        rk = shadow_key[0];
        rt = shadow_tag[0];
        shadow_fill--;
        shadow_key[0] = shadow_key[shadow_fill];
        shadow_tag[0] = shadow_tag[shadow_fill];
        pos = 0;
        forever begin
          best = pos;
          if (2*pos+1 < shadow_fill && shadow_key[2*pos+1] < shadow_key[best])
            best = 2*pos+1;
          if (2*pos+2 < shadow_fill && shadow_key[2*pos+2] < shadow_key[best])
            best = 2*pos+2;
          if (best == pos) break;
          swap_slot(pos, best);
          pos = best;
        end
      end
    end
    return mk_rsp(rk, rt, st, shadow_fill);
  endfunction

  // Clock.
  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Drive one beat and hold it until accepted.
  task automatic send_beat(req_t rq);
    in_valid <= 1'b1;
    in_data <= rq;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic idle_gap(int n);
    in_valid <= 1'b0;
    repeat (n) @(negedge clk);
  endtask

  function automatic req_t rand_req(int ins_weight);
    req_t r;
    r.req_type = ($urandom_range(99) < ins_weight) ? REQ_INSERT : REQ_EXTRACT;
    case ($urandom_range(3))
      0: r.key = 31'($urandom_range(7));
      1: r.key = 31'($urandom);
      2: r.key = 31'h7fff_ffff - 31'($urandom_range(3));
      default: r.key = 31'($urandom_range(1000));
    endcase
    r.tag = 16'($urandom);
    return r;
  endfunction

  // Compare each accepted response beat against the oldest prediction.
  always @(posedge clk) begin
    rsp_t exp_rsp;
    if (!rst && out_valid && !out_stall) begin
      if (pending_rsp.size() == 0) begin
        $display("%0t: unexpected beat, expected none, actual %h", $time, out_data);
        err_count++;
      end else begin
        exp_rsp = pending_rsp.pop_front();
        if (out_data.out_key !== exp_rsp.out_key) begin
          $display("%0t: out_key expected %h actual %h", $time, exp_rsp.out_key,
                   out_data.out_key);
          err_count++;
        end
        if (out_data.out_tag !== exp_rsp.out_tag) begin
          $display("%0t: out_tag expected %h actual %h", $time, exp_rsp.out_tag,
                   out_data.out_tag);
          err_count++;
        end
        if (out_data.status !== exp_rsp.status) begin
          $display("%0t: status expected %h actual %h", $time, exp_rsp.status,
                   out_data.status);
          err_count++;
        end
        if (out_data.now_empty !== exp_rsp.now_empty) begin
          $display("%0t: now_empty expected %h actual %h", $time, exp_rsp.now_empty,
                   out_data.now_empty);
          err_count++;
        end
        if (out_data.entry_count !== exp_rsp.entry_count) begin
          $display("%0t: entry_count expected %0d actual %0d", $time,
                   exp_rsp.entry_count, out_data.entry_count);
          err_count++;
        end
      end
      // A directed row with a typed result is checked against it as well.
      if (fix_armed) begin
        fix_armed = 1'b0;
        if (out_data !== fix_rsp) begin
          $display("%0t: typed result expected %h actual %h", $time, fix_rsp,
                   out_data);
          err_count++;
        end
      end
    end
  end

  // Predict on each accepted request beat.
  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall) pending_rsp = {pending_rsp, heap_apply(in_data)};
  end

  // Receiver stall pattern, with one long hold-off on request.
  initial begin
    int mode;
    out_stall = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        out_stall <= 1'b1;
        repeat (3000) @(negedge clk);
        long_hold = 1'b0;
      end
      mode = $urandom_range(9);
      if (mode < 3) out_stall <= 1'b0;
      else if (mode < 7) out_stall <= $urandom_range(1);
      else out_stall <= ($urandom_range(3) == 0);
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
  end

  // Watchdog on cycles with no beat moving.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 20000) begin
      $display("tb: failure");
      $finish;
    end
  end

  initial begin
    dir_row_t dir_rows [$];
    dir_row_t row;
    req_t rq;
    int n;
    int burst;
    int ins_weight;
    err_count = 0;
    shadow_fill = 0;
    send_done = 0;
    long_hold = 0;
    idle_cycles = 0;
    fix_armed = 1'b0;
    fix_rsp = '0;
    rst = 1'b1;
    in_valid = 1'b0;
    in_data = '0;

    // Directed table: empty extract, extremes, ties, drain.
    row.check_fixed = 1;
    row.req = '{REQ_EXTRACT, 31'h7fff_ffff, 16'hffff};
    row.fixed = mk_rsp('0, '0, ST_EMPTY, 0);
    dir_rows = {dir_rows, row};
    row.req = '{REQ_INSERT, 31'h7fff_ffff, 16'hffff};
    row.fixed = mk_rsp('0, '0, ST_DONE, 1);
    dir_rows = {dir_rows, row};
    row.req = '{REQ_EXTRACT, '0, '0};
    row.fixed = mk_rsp(31'h7fff_ffff, 16'hffff, ST_DONE, 0);
    dir_rows = {dir_rows, row};
    row.check_fixed = 0;
    begin
      logic [KEY_W-1:0] ks [10] = '{5, 3, 3, 0, 31'h7fff_ffff, 3, 1, 5, 0, 2};
      for (int i = 0; i < 10; i++) begin
        row.req = '{REQ_INSERT, ks[i], 16'(i + 16'h5a00)};
        dir_rows = {dir_rows, row};
      end
      for (int i = 0; i < 11; i++) begin
        row.req = '{REQ_EXTRACT, '0, '0};
        dir_rows = {dir_rows, row};
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    foreach (dir_rows[i]) begin
      if (dir_rows[i].check_fixed) begin
        fix_rsp = dir_rows[i].fixed;
        fix_armed = 1'b1;
        send_beat(dir_rows[i].req);
        in_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(negedge clk);
      end else begin
        send_beat(dir_rows[i].req);
      end
    end
    in_valid <= 1'b0;

    // Random part: bursts with varied insert bias.
    n = 0;
    while (n < 420) begin
      ins_weight = (n < 300) ? 75 : 45;
      burst = $urandom_range(1, 30);
      repeat (burst) begin
        send_beat(rand_req(ins_weight));
        n++;
      end
      if ($urandom_range(3) == 0) idle_gap(0);
      else idle_gap($urandom_range(1, 40));
      in_valid <= 1'b0;
    end

    // Fill to full, opening with one long receiver hold-off, overfill, then drain part way.
    while (pending_rsp.size() != 0) @(negedge clk);
    long_hold = 1;
    while (shadow_fill < HEAP_DEPTH) begin
      rq = rand_req(100);
      send_beat(rq);
    end
    for (int i = 0; i < 4; i++) begin
      rq = rand_req(100);
      send_beat(rq);
    end
    for (int i = 0; i < 270; i++) begin
      rq = rand_req(20);
      send_beat(rq);
      if ($urandom_range(15) == 0) idle_gap($urandom_range(1, 20));
    end
    in_valid <= 1'b0;
    send_done = 1;

    while (pending_rsp.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    if (err_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
